[hdl/aes_enc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_enc_pkg
// Shared types, constants and round functions for the AES-128 encrypt core.
// ----------------------------------------------------------------------------
package aes_enc_pkg;

    localparam int ROUNDS    = 10;
    localparam int KEY_WORDS = 4;
    localparam int HALF_W    = 64;
    localparam int BLOCK_W   = 128;
    localparam int ADDR_W    = 4;

    localparam logic [ADDR_W-1:0] ADDR_KEY_HIGH = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_KEY_LOW  = 4'h8;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [HALF_W-1:0]  half_t;
    typedef logic [7:0]         byte_t;
    typedef logic [3:0]         round_idx_t;

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // round constants for rounds 1 to 10, entry 0 unused
    localparam byte_t RCON [16] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,
        8'h80,8'h1b,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00
    };

    function automatic byte_t xtime(input byte_t b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the state sits at bits 127-8i down
    function automatic byte_t get_byte(input block_t s, input int i);
        get_byte = s[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic block_t sub_shift(input block_t s);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[BLOCK_W-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
        sub_shift = t;
    endfunction

    function automatic block_t mix_columns(input block_t s);
        block_t t;
        byte_t a0, a1, a2, a3, d0, d1, d2, d3;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            d0 = xtime(a0);
            d1 = xtime(a1);
            d2 = xtime(a2);
            d3 = xtime(a3);
            t[BLOCK_W-1-8*(4*c)   -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
            t[BLOCK_W-1-8*(4*c+1) -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
            t[BLOCK_W-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
            t[BLOCK_W-1-8*(4*c+3) -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
        end
        mix_columns = t;
    endfunction

    // one step of the key schedule: round key r-1 to round key r
    function automatic block_t next_key(input block_t k, input byte_t rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        t  = t ^ {rc, 24'h000000};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

endpackage

[hdl/aes_enc_block_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_enc_block_if
// Plaintext word channel: valid/ready with the two block halves.
// ----------------------------------------------------------------------------
interface aes_enc_block_if;
    logic                 valid;
    logic                 ready;
    aes_enc_pkg::half_t   block_high;
    aes_enc_pkg::half_t   block_low;

    modport source (output valid, output block_high, output block_low, input ready);
    modport sink   (input valid, input block_high, input block_low, output ready);
endinterface

[hdl/aes_enc_cipher_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_enc_cipher_if
// Ciphertext word channel: valid/ready with the two block halves.
// ----------------------------------------------------------------------------
interface aes_enc_cipher_if;
    logic                 valid;
    logic                 ready;
    aes_enc_pkg::half_t   cipher_high;
    aes_enc_pkg::half_t   cipher_low;

    modport source (output valid, output cipher_high, output cipher_low, input ready);
    modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface

[hdl/aes128_block_encrypt_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_encrypt_core
// AES-128 encryption, fully unrolled into an eleven-stage pipeline.
// ----------------------------------------------------------------------------
// One plaintext word is taken every cycle unless the output stalls. There
// is one register stage for the initial key add, then one per round, the
// last of which is the output register. Each round stage holds one
// SubBytes/ShiftRows/MixColumns/AddRoundKey (without MixColumns in the
// last round) and one key schedule step; the round key travels down the
// pipeline with its block. When the output is not taken the whole pipeline
// holds. The key sits at byte addresses 0x0 (key bytes 0..7) and 0x8
// (bytes 8..15) and must only be changed while no word is in flight.
module aes128_block_encrypt_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aes_enc_pkg::ADDR_W-1:0]    paddr,
    input  logic [aes_enc_pkg::HALF_W-1:0]    pwdata,
    output logic [aes_enc_pkg::HALF_W-1:0]    prdata,
    output logic                              pready,
    aes_enc_block_if.sink                     plaintext,
    aes_enc_cipher_if.source                  ciphertext
);

    aes_enc_pkg::half_t  key_high_reg;
    aes_enc_pkg::half_t  key_low_reg;

    logic                 valid_reg [aes_enc_pkg::ROUNDS+1];
    aes_enc_pkg::block_t  state_reg [aes_enc_pkg::ROUNDS+1];
    aes_enc_pkg::block_t  rkey_reg  [aes_enc_pkg::ROUNDS];
    aes_enc_pkg::block_t  state_next [aes_enc_pkg::ROUNDS+1];
    aes_enc_pkg::block_t  rkey_next  [aes_enc_pkg::ROUNDS+1];

    logic                 advance;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    // only the 64-bit slot bit selects the register
    assign prdata = paddr[3] ? key_low_reg : key_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (wr_en)
        begin
            if (paddr[3] == aes_enc_pkg::ADDR_KEY_LOW[3])
                key_low_reg <= pwdata;
            else
                key_high_reg <= pwdata;
        end
    end

    // hold every stage while the output word waits
    assign advance         = !valid_reg[aes_enc_pkg::ROUNDS] || ciphertext.ready;
    assign plaintext.ready = advance;

    always_comb
    begin
        rkey_next[0]  = {key_high_reg, key_low_reg};
        state_next[0] = {plaintext.block_high, plaintext.block_low} ^ rkey_next[0];
        for (int r = 1; r <= aes_enc_pkg::ROUNDS; r++)
        begin
            rkey_next[r] = aes_enc_pkg::next_key(rkey_reg[r-1],
                                                 aes_enc_pkg::RCON[r]);
            if (r == aes_enc_pkg::ROUNDS)
                state_next[r] = aes_enc_pkg::sub_shift(state_reg[r-1]) ^ rkey_next[r];
            else
                state_next[r] = aes_enc_pkg::mix_columns(
                                    aes_enc_pkg::sub_shift(state_reg[r-1])) ^ rkey_next[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r <= aes_enc_pkg::ROUNDS; r++)
                valid_reg[r] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= plaintext.valid;
            for (int r = 1; r <= aes_enc_pkg::ROUNDS; r++)
                valid_reg[r] <= valid_reg[r-1];
        end
    end

    // the last round key is consumed in the output stage, so no register for it
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int r = 0; r <= aes_enc_pkg::ROUNDS; r++)
                state_reg[r] <= state_next[r];
            for (int r = 0; r < aes_enc_pkg::ROUNDS; r++)
                rkey_reg[r] <= rkey_next[r];
        end
    end

    assign ciphertext.valid       = valid_reg[aes_enc_pkg::ROUNDS];
    assign ciphertext.cipher_high = state_reg[aes_enc_pkg::ROUNDS][127:64];
    assign ciphertext.cipher_low  = state_reg[aes_enc_pkg::ROUNDS][63:0];

endmodule

[tb/aes128_block_encrypt_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_encrypt_core_tb
// Self-checking bench for the AES-128 encrypt pipeline.
// ----------------------------------------------------------------------------
// A behavioural AES-128 encryptor predicts each ciphertext word from the key
// held in the bench. Plaintext goes in bursts with random gaps, the output
// side stalls on its own pattern, and the key is rewritten between phases
// once the pipeline has drained.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_core_tb;

    localparam int PIPE_DEPTH = 11;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        aes_enc_pkg::half_t hi;
        aes_enc_pkg::half_t lo;
    } cipher_word_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [aes_enc_pkg::ADDR_W-1:0] paddr;
    logic [aes_enc_pkg::HALF_W-1:0] pwdata;
    logic [aes_enc_pkg::HALF_W-1:0] prdata;
    logic pready;

    aes_enc_block_if  plain_ch ();
    aes_enc_cipher_if cipher_ch ();

    aes128_block_encrypt_core DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .plaintext  (plain_ch.sink),
        .ciphertext (cipher_ch.source)
    );

    aes_enc_pkg::half_t cur_key_hi;
    aes_enc_pkg::half_t cur_key_lo;
    cipher_word_t       cipher_due [$];
    int                 errors;
    int                 words_sent;
    int                 words_checked;
    int                 cycles;
    int                 stall_mode;

    localparam aes_enc_pkg::byte_t SB [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic aes_enc_pkg::byte_t gdouble(aes_enc_pkg::byte_t b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // state held as 16 bytes, column-major like the standard
    function automatic cipher_word_t aes_encrypt(aes_enc_pkg::half_t khi,
                                                 aes_enc_pkg::half_t klo,
                                                 aes_enc_pkg::half_t phi,
                                                 aes_enc_pkg::half_t plo);
        logic [31:0]        ks [44];
        aes_enc_pkg::byte_t st [16];
        aes_enc_pkg::byte_t tmp [16];
        aes_enc_pkg::byte_t a0, a1, a2, a3;
        logic [127:0]       kk;
        logic [127:0]       pp;
        logic [31:0]        t;
        aes_enc_pkg::byte_t rc;
        cipher_word_t       res;
        kk = {khi, klo};
        pp = {phi, plo};
        rc = 8'h01;
        for (int i = 0; i < 4; i++)
            ks[i] = kk[127-32*i -: 32];
        for (int i = 4; i < 44; i++)
        begin
            t = ks[i-1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {SB[t[31:24]], SB[t[23:16]], SB[t[15:8]], SB[t[7:0]]} ^ {rc, 24'h0};
                rc = gdouble(rc);
            end
            ks[i] = ks[i-4] ^ t;
        end
        for (int i = 0; i < 16; i++)
            st[i] = pp[127-8*i -: 8] ^ ks[i/4][31-8*(i%4) -: 8];
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[4*c+r] = SB[st[4*((c+r)%4)+r]];
            if (rnd < 10)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
                    tmp[4*c]   = gdouble(a0) ^ gdouble(a1) ^ a1 ^ a2 ^ a3;
                    tmp[4*c+1] = a0 ^ gdouble(a1) ^ gdouble(a2) ^ a2 ^ a3;
                    tmp[4*c+2] = a0 ^ a1 ^ gdouble(a2) ^ gdouble(a3) ^ a3;
                    tmp[4*c+3] = gdouble(a0) ^ a0 ^ a1 ^ a2 ^ gdouble(a3);
                end
            for (int i = 0; i < 16; i++)
                st[i] = tmp[i] ^ ks[4*rnd + i/4][31-8*(i%4) -: 8];
        end
        for (int i = 0; i < 16; i++)
            pp[127-8*i -: 8] = st[i];
        res.hi = pp[127:64];
        res.lo = pp[63:0];
        return res;
    endfunction

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** aes128_block_encrypt_core: FAILED **");
            $finish;
        end
    end

    // output stall pattern: mode chosen per stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_ch.ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0: cipher_ch.ready <= 1'b1;
                1: cipher_ch.ready <= ($urandom_range(0, 3) != 0);
                2: cipher_ch.ready <= ($urandom_range(0, 3) == 0);
                default: cipher_ch.ready <= ((cycles % 7) < 4);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((cycles % 300) == 0)
            stall_mode <= $urandom_range(0, 3);
    end

    always @(posedge clk)
    begin
        cipher_word_t exp_w;
        if (rst_n && cipher_ch.valid && cipher_ch.ready)
        begin
            if (cipher_due.size() == 0)
            begin
                $error("unexpected ciphertext word %h %h", cipher_ch.cipher_high,
                       cipher_ch.cipher_low);
                errors++;
            end
            else
            begin
                exp_w = cipher_due.pop_front();
                words_checked++;
                if (cipher_ch.cipher_high !== exp_w.hi)
                begin
                    $error("cipher_high expected %h actual %h", exp_w.hi, cipher_ch.cipher_high);
                    errors++;
                end
                if (cipher_ch.cipher_low !== exp_w.lo)
                begin
                    $error("cipher_low expected %h actual %h", exp_w.lo, cipher_ch.cipher_low);
                    errors++;
                end
            end
        end
    end

    task automatic write_key_reg(logic [aes_enc_pkg::ADDR_W-1:0] addr,
                                 aes_enc_pkg::half_t value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == aes_enc_pkg::ADDR_KEY_HIGH)
            cur_key_hi = value;
        else if (addr == aes_enc_pkg::ADDR_KEY_LOW)
            cur_key_lo = value;
    endtask

    // wait for the pipeline to empty before touching the key
    task automatic drain_pipe();
        while (cipher_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic set_key(aes_enc_pkg::half_t hi, aes_enc_pkg::half_t lo);
        drain_pipe();
        write_key_reg(aes_enc_pkg::ADDR_KEY_HIGH, hi);
        write_key_reg(aes_enc_pkg::ADDR_KEY_LOW, lo);
    endtask

    // keep valid high across back-to-back words; drop it only for a gap
    task automatic send_block(aes_enc_pkg::half_t hi, aes_enc_pkg::half_t lo, bit hold_after);
        plain_ch.valid      <= 1'b1;
        plain_ch.block_high <= hi;
        plain_ch.block_low  <= lo;
        do @(posedge clk); while (!plain_ch.ready);
        cipher_due.push_back(aes_encrypt(cur_key_hi, cur_key_lo, hi, lo));
        words_sent++;
        if (!hold_after)
            plain_ch.valid <= 1'b0;
    endtask

    function automatic aes_enc_pkg::half_t rand_half(int kind);
        case (kind)
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_reset_key();
        send_block('0, '0, 1'b1);
        send_block('1, '1, 1'b0);
        @(posedge clk);
    endtask

    task automatic test_known_vectors();
        set_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b1);
        send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b0);
        set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        @(posedge clk);
    endtask

    task automatic test_extremes();
        aes_enc_pkg::half_t ext [4];
        ext[0] = '0;
        ext[1] = '1;
        ext[2] = 64'h8000000000000001;
        ext[3] = 64'h5555aaaa5555aaaa;
        set_key('1, '1);
        for (int i = 0; i < 4; i++)
            send_block(ext[i], ext[3-i], i != 3);
        set_key('0, '1);
        for (int i = 0; i < 4; i++)
            send_block(ext[i], ext[i], i != 3);
        set_key('1, '0);
        send_block('0, '1, 1'b0);
        @(posedge clk);
    endtask

    task automatic test_random_stream(int n_words);
        int burst;
        int left;
        left = n_words;
        while (left > 0)
        begin
            if ($urandom_range(0, 7) == 0)
                set_key(rand_half($urandom_range(0, 9)), rand_half($urandom_range(0, 9)));
            burst = $urandom_range(1, 40);
            if (burst > left)
                burst = left;
            for (int i = 0; i < burst; i++)
                send_block(rand_half($urandom_range(0, 15)), rand_half($urandom_range(0, 15)),
                           i != burst - 1);
            left -= burst;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            if ($urandom_range(0, 19) == 0)
                drain_pipe();
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        plain_ch.valid      = 1'b0;
        plain_ch.block_high = '0;
        plain_ch.block_low  = '0;
        cur_key_hi          = '0;
        cur_key_lo          = '0;
        errors              = 0;
        words_sent          = 0;
        words_checked       = 0;
        cycles              = 0;
        stall_mode          = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_key();
        test_known_vectors();
        test_extremes();
        drain_pipe();
        test_random_stream(1600);
        drain_pipe();

        $display("Encrypted %0d words, %0d checked,", words_sent, words_checked);
        $display("under reset, standard, extreme and random keys with output stalls.");
        if (errors == 0)
            $display("** aes128_block_encrypt_core: PASSED **");
        else
            $display("** aes128_block_encrypt_core: FAILED **");
        $finish;
    end

endmodule
